[hdl/gds_pkg.sv]
`timescale 1ns / 1ps

package gds_pkg;

   localparam int GDS_MAX_VERTICES = 64;
   localparam int GDS_MAX_ENTRIES  = 1024;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 8;
   localparam int RSP_USER_W = 2;

   typedef enum logic [1:0] {
      OP_OPEN   = 2'd0,
      OP_APPEND = 2'd1,
      OP_FINISH = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_VERT,
      ST_LIST,
      ST_ENT_RD,
      ST_ENT_EV,
      ST_PUSH,
      ST_FINAL
   } state_type;

endpackage

[hdl/greedy_dominating_set.sv]
`timescale 1ns / 1ps
// Load transactions (open, append, other) are taken one per cycle, req_tready held high.
// Finish: each greedy round skips dominated vertices, scores each undominated vertex by
// reading its list and then its entries, closes the scan, and reads the chosen vertex's
// entries again to mark them. Rounds <= vertices; list and entry reads each use one port.
// Results leave through one output register; an empty graph gives a single result.
// Synchronous reset clears control, vt/et counts, marks; entry and list memories keep junk.

module greedy_dominating_set import gds_pkg::*; #(
   parameter int MAX_VERTICES = GDS_MAX_VERTICES,
   parameter int MAX_ENTRIES  = GDS_MAX_ENTRIES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // operation[1:0], neighbor[17:2], zero pad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // chosen_vertex[5:0], zero pad
   output logic                  rsp_tlast,   // last_of_set
   output logic [RSP_USER_W-1:0] rsp_tuser    // empty_graph[0], overflow[1]
);

   localparam int VW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int VCW = $clog2(MAX_VERTICES + 1);
   localparam int EW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int ETW = $clog2(MAX_ENTRIES + 1);
   localparam int CW  = $clog2(MAX_ENTRIES + 2);

   logic [15:0]    entry_mem [MAX_ENTRIES];
   logic [ETW-1:0] start_mem [MAX_VERTICES];
   logic [ETW-1:0] len_mem   [MAX_VERTICES];

   state_type         state_ff, state_in;
   logic [VCW-1:0]    vt_ff, vt_in;
   logic [ETW-1:0]    et_ff, et_in;
   logic              dropped_ff, dropped_in;
   logic              open_dropped_ff, open_dropped_in;
   logic [ETW-1:0]    cur_start_ff, cur_start_in;
   logic [ETW-1:0]    cur_len_ff, cur_len_in;
   logic [MAX_VERTICES-1:0] dom_ff, dom_in;
   logic [VCW-1:0]    v_ff, v_in;
   logic [ETW-1:0]    ptr_ff, ptr_in;
   logic [ETW-1:0]    rem_ff, rem_in;
   logic [CW-1:0]     cov_ff, cov_in;
   logic [CW-1:0]     best_cov_ff, best_cov_in;
   logic [VW-1:0]     best_ff, best_in;
   logic              mark_ff, mark_in;
   logic [VW-1:0]     pend_ff, pend_in;
   logic              pend_valid_ff, pend_valid_in;
   logic              empty_ff, empty_in;

   logic              out_valid_ff, out_valid_in;
   logic [5:0]        out_vertex_ff, out_vertex_in;
   logic              out_last_ff, out_last_in;
   logic              out_empty_ff, out_empty_in;
   logic              out_ovf_ff, out_ovf_in;

   logic [15:0]       entry_rd_ff;
   logic [ETW-1:0]    start_rd_ff;
   logic [ETW-1:0]    len_rd_ff;

   logic              entry_we;
   logic              list_we;
   logic [VW-1:0]     list_waddr;
   logic [ETW-1:0]    list_wstart;
   logic [ETW-1:0]    list_wlen;
   logic [VW-1:0]     list_raddr;

   logic [1:0]        req_op;
   logic [15:0]       req_nb;
   logic              req_fire;
   logic              out_free;
   logic              in_range;

   assign req_op     = req_tdata[1:0];
   assign req_nb     = req_tdata[17:2];
   assign req_tready = (state_ff == ST_LOAD);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign in_range   = entry_rd_ff < 16'(vt_ff);
   assign list_raddr = (state_ff == ST_PUSH) ? best_ff : v_ff[VW-1:0];

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_vertex_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = {out_ovf_ff, out_empty_ff};

   always_ff @(posedge clock) begin
      if (entry_we) begin
         entry_mem[et_ff[EW-1:0]] <= req_nb;
      end
      entry_rd_ff <= entry_mem[ptr_ff[EW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (list_we) begin
         start_mem[list_waddr] <= list_wstart;
         len_mem[list_waddr]   <= list_wlen;
      end
      start_rd_ff <= start_mem[list_raddr];
      len_rd_ff   <= len_mem[list_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_LOAD;
         vt_ff           <= '0;
         et_ff           <= '0;
         dropped_ff      <= 1'b0;
         open_dropped_ff <= 1'b0;
         dom_ff          <= '0;
         pend_valid_ff   <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         vt_ff           <= vt_in;
         et_ff           <= et_in;
         dropped_ff      <= dropped_in;
         open_dropped_ff <= open_dropped_in;
         dom_ff          <= dom_in;
         pend_valid_ff   <= pend_valid_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_start_ff  <= cur_start_in;
      cur_len_ff    <= cur_len_in;
      v_ff          <= v_in;
      ptr_ff        <= ptr_in;
      rem_ff        <= rem_in;
      cov_ff        <= cov_in;
      best_cov_ff   <= best_cov_in;
      best_ff       <= best_in;
      mark_ff       <= mark_in;
      pend_ff       <= pend_in;
      empty_ff      <= empty_in;
      out_vertex_ff <= out_vertex_in;
      out_last_ff   <= out_last_in;
      out_empty_ff  <= out_empty_in;
      out_ovf_ff    <= out_ovf_in;
   end

   always_comb begin
      state_in        = state_ff;
      vt_in           = vt_ff;
      et_in           = et_ff;
      dropped_in      = dropped_ff;
      open_dropped_in = open_dropped_ff;
      cur_start_in    = cur_start_ff;
      cur_len_in      = cur_len_ff;
      dom_in          = dom_ff;
      v_in            = v_ff;
      ptr_in          = ptr_ff;
      rem_in          = rem_ff;
      cov_in          = cov_ff;
      best_cov_in     = best_cov_ff;
      best_in         = best_ff;
      mark_in         = mark_ff;
      pend_in         = pend_ff;
      pend_valid_in   = pend_valid_ff;
      empty_in        = empty_ff;
      out_valid_in    = out_valid_ff && !rsp_tready;
      out_vertex_in   = out_vertex_ff;
      out_last_in     = out_last_ff;
      out_empty_in    = out_empty_ff;
      out_ovf_in      = out_ovf_ff;
      entry_we        = 1'b0;
      list_we         = 1'b0;
      list_waddr      = vt_ff[VW-1:0];
      list_wstart     = et_ff;
      list_wlen       = '0;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               unique case (req_op)
                  OP_OPEN: begin
                     if (vt_ff != VCW'(MAX_VERTICES)) begin
                        list_we         = 1'b1;
                        cur_start_in    = et_ff;
                        cur_len_in      = '0;
                        vt_in           = vt_ff + 1'b1;
                        open_dropped_in = 1'b0;
                     end else begin
                        dropped_in      = 1'b1;
                        open_dropped_in = 1'b1;
                     end
                  end
                  OP_APPEND: begin
                     if (vt_ff != '0) begin
                        if (open_dropped_ff || et_ff == ETW'(MAX_ENTRIES)) begin
                           dropped_in = 1'b1;
                        end else begin
                           entry_we    = 1'b1;
                           et_in       = et_ff + 1'b1;
                           cur_len_in  = cur_len_ff + 1'b1;
                           list_we     = 1'b1;
                           list_waddr  = VW'(vt_ff - 1'b1);
                           list_wstart = cur_start_ff;
                           list_wlen   = cur_len_ff + 1'b1;
                        end
                     end
                  end
                  OP_FINISH: begin
                     pend_in       = '0;
                     pend_valid_in = 1'b0;
                     dom_in        = '0;
                     v_in          = '0;
                     best_cov_in   = '0;
                     mark_in       = 1'b0;
                     if (vt_ff == '0) begin
                        empty_in      = 1'b1;
                        pend_valid_in = 1'b1;
                        state_in      = ST_FINAL;
                     end else begin
                        empty_in = 1'b0;
                        state_in = ST_VERT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_VERT: begin
            if (v_ff == vt_ff) begin
               state_in = (best_cov_ff != '0) ? ST_PUSH : ST_FINAL;
            end else if (dom_ff[v_ff[VW-1:0]]) begin
               v_in = v_ff + 1'b1;
            end else begin
               state_in = ST_LIST;
            end
         end
         ST_LIST: begin
            ptr_in   = start_rd_ff;
            rem_in   = len_rd_ff;
            cov_in   = CW'(1);
            state_in = ST_ENT_RD;
         end
         ST_ENT_RD: begin
            if (rem_ff == '0) begin
               state_in = ST_VERT;
               if (mark_ff) begin
                  v_in        = '0;
                  best_cov_in = '0;
                  mark_in     = 1'b0;
               end else begin
                  if (cov_ff > best_cov_ff) begin
                     best_cov_in = cov_ff;
                     best_in     = v_ff[VW-1:0];
                  end
                  v_in = v_ff + 1'b1;
               end
            end else begin
               state_in = ST_ENT_EV;
            end
         end
         ST_ENT_EV: begin
            if (in_range) begin
               if (mark_ff) begin
                  dom_in[entry_rd_ff[VW-1:0]] = 1'b1;
               end else if (!dom_ff[entry_rd_ff[VW-1:0]]) begin
                  cov_in = cov_ff + 1'b1;
               end
            end
            ptr_in   = ptr_ff + 1'b1;
            rem_in   = rem_ff - 1'b1;
            state_in = ST_ENT_RD;
         end
         ST_PUSH: begin
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  out_valid_in  = 1'b1;
                  out_vertex_in = 6'(pend_ff);
                  out_last_in   = 1'b0;
                  out_empty_in  = 1'b0;
                  out_ovf_in    = dropped_ff;
               end
               pend_in          = best_ff;
               pend_valid_in    = 1'b1;
               dom_in[best_ff]  = 1'b1;
               mark_in          = 1'b1;
               state_in         = ST_LIST;
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               out_valid_in    = 1'b1;
               out_vertex_in   = 6'(pend_ff);
               out_last_in     = 1'b1;
               out_empty_in    = empty_ff;
               out_ovf_in      = dropped_ff;
               pend_valid_in   = 1'b0;
               vt_in           = '0;
               et_in           = '0;
               dropped_in      = 1'b0;
               open_dropped_in = 1'b0;
               state_in        = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule

[hdl/gds_checker.sv]
`timescale 1ns / 1ps

module gds_checker import gds_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast,
   input logic [RSP_USER_W-1:0] rsp_tuser
);

   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("block not idle after reset");

   a_finish_stalls: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tdata[1:0] == OP_FINISH |=> !req_tready)
      else $error("finish transaction did not stall the input");

   a_empty_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast && rsp_tdata == '0)
      else $error("empty graph result malformed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result transaction changed");

endmodule

bind greedy_dominating_set gds_checker u_gds_checker (.*);

[dv/tb_greedy_dominating_set.sv]
`timescale 1ns / 1ps

module tb_greedy_dominating_set;
   import gds_pkg::*;

   localparam logic [1:0] OP_UNUSED     = 2'd3;
   localparam int         WATCHDOG_MAX  = 200000;
   localparam int         SETTLE_CYCLES = 64;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] nb;
      logic        hold;
      logic [1:0]  phase;
   } graph_item_type;

   typedef struct packed {
      logic [5:0] vertex;
      logic       last;
      logic       empty;
      logic       overflow;
   } pick_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic [RSP_USER_W-1:0] rsp_tuser;

   greedy_dominating_set uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   graph_item_type pending_ops[$];
   pick_type       picks_due[$];
   graph_item_type on_bus;
   logic [1:0]  phase       = 2'd0;
   int          items_taken = 0;
   int          fail_count  = 0;
   int          quiet_cycles = 0;

   // shadow of the loaded graph
   logic [15:0] g_store [GDS_MAX_ENTRIES];
   int unsigned g_start [GDS_MAX_VERTICES];
   int unsigned g_len   [GDS_MAX_VERTICES];
   int unsigned g_vertices = 0;
   int unsigned g_entries  = 0;
   bit          g_dropped  = 1'b0;
   bit          g_open_lost = 1'b0;

   function automatic int idle_pct(logic [1:0] ph, bit receiver);
      case (ph)
         2'd0:    idle_pct = receiver ? 67 : 26;
         2'd1:    idle_pct = receiver ? 26 : 67;
         default: idle_pct = 0;
      endcase
   endfunction

   function automatic void add_item(logic [1:0] op, logic [15:0] nb, bit hold, logic [1:0] ph);
      graph_item_type it;
      it.op    = op;
      it.nb    = nb;
      it.hold  = hold;
      it.phase = ph;
      pending_ops.push_back(it);
   endfunction

   task automatic track_item(input graph_item_type it);
      bit          marked [GDS_MAX_VERTICES];
      int          found[$];
      int          best;
      int unsigned best_cov;
      int unsigned cov;
      int unsigned t;
      pick_type    p;
      case (it.op)
         OP_OPEN: begin
            if (g_vertices < GDS_MAX_VERTICES) begin
               g_start[g_vertices] = g_entries;
               g_len[g_vertices]   = 0;
               g_vertices++;
               g_open_lost = 1'b0;
            end else begin
               g_dropped   = 1'b1;
               g_open_lost = 1'b1;
            end
         end
         OP_APPEND: begin
            if (g_vertices != 0) begin
               if (g_open_lost || g_entries >= GDS_MAX_ENTRIES) begin
                  g_dropped = 1'b1;
               end else begin
                  g_store[g_entries] = it.nb;
                  g_entries++;
                  g_len[g_vertices - 1]++;
               end
            end
         end
         OP_FINISH: begin
            if (g_vertices == 0) begin
               p.vertex   = '0;
               p.last     = 1'b1;
               p.empty    = 1'b1;
               p.overflow = g_dropped;
               picks_due.push_back(p);
            end else begin
               foreach (marked[i]) marked[i] = 1'b0;
               do begin
                  best     = -1;
                  best_cov = 0;
                  for (int v = 0; v < g_vertices; v++) begin
                     if (!marked[v]) begin
                        cov = 1;
                        for (int i = 0; i < g_len[v]; i++) begin
                           t = g_store[g_start[v] + i];
                           if (t < g_vertices && !marked[t]) cov++;
                        end
                        if (cov > best_cov) begin
                           best_cov = cov;
                           best     = v;
                        end
                     end
                  end
                  if (best >= 0) begin
                     marked[best] = 1'b1;
                     for (int i = 0; i < g_len[best]; i++) begin
                        t = g_store[g_start[best] + i];
                        if (t < g_vertices) marked[t] = 1'b1;
                     end
                     found.push_back(best);
                  end
               end while (best >= 0);
               foreach (found[i]) begin
                  p.vertex   = 6'(found[i]);
                  p.last     = (i == found.size() - 1);
                  p.empty    = 1'b0;
                  p.overflow = g_dropped;
                  picks_due.push_back(p);
               end
            end
            g_vertices  = 0;
            g_entries   = 0;
            g_dropped   = 1'b0;
            g_open_lost = 1'b0;
         end
         default: ;
      endcase
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            track_item(on_bus);
            items_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_ops.size() != 0
                && !(pending_ops[0].hold && picks_due.size() != 0)
                && $urandom_range(99) >= idle_pct(pending_ops[0].phase, 1'b0)) begin
               on_bus = pending_ops.pop_front();
               phase      <= on_bus.phase;
               req_tvalid <= 1'b1;
               req_tdata  <= {{(REQ_DATA_W - 18){1'b0}}, on_bus.nb, on_bus.op};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      pick_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (picks_due.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, actual %0d last %0b user %b",
                        $time, rsp_tdata, rsp_tlast, rsp_tuser);
               fail_count++;
            end else begin
               want = picks_due.pop_front();
               if (rsp_tdata !== {{(RSP_DATA_W - 6){1'b0}}, want.vertex}) begin
                  $display("%0t: chosen_vertex expected %0d actual %0d",
                           $time, want.vertex, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $display("%0t: last_of_set expected %0b actual %0b",
                           $time, want.last, rsp_tlast);
                  fail_count++;
               end
               if (rsp_tuser[0] !== want.empty) begin
                  $display("%0t: empty_graph expected %0b actual %0b",
                           $time, want.empty, rsp_tuser[0]);
                  fail_count++;
               end
               if (rsp_tuser[1] !== want.overflow) begin
                  $display("%0t: overflow expected %0b actual %0b",
                           $time, want.overflow, rsp_tuser[1]);
                  fail_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= idle_pct(phase, 1'b1));
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_MAX);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      int          total;
      int          rand_count;
      int          graphs_made;
      int unsigned nv;
      int unsigned deg;
      int unsigned pick;
      logic [15:0] nb;
      logic [1:0]  ph;

      // append before any open, unused operation, empty graph
      add_item(OP_APPEND, 16'h8000, 1'b0, 2'd0);
      add_item(OP_UNUSED, 16'hFFFF, 1'b0, 2'd0);
      add_item(OP_FINISH, 16'h0000, 1'b0, 2'd0);
      // field extremes, duplicates, out-of-range entries
      add_item(OP_OPEN,   16'hFFFF, 1'b0, 2'd0);
      add_item(OP_APPEND, 16'h7FFF, 1'b0, 2'd0);
      add_item(OP_APPEND, 16'h8000, 1'b0, 2'd0);
      add_item(OP_APPEND, 16'h0000, 1'b0, 2'd0);
      add_item(OP_APPEND, 16'h0001, 1'b0, 2'd0);
      add_item(OP_APPEND, 16'h0001, 1'b0, 2'd0);
      add_item(OP_UNUSED, 16'h5555, 1'b0, 2'd0);
      add_item(OP_OPEN,   16'h0000, 1'b0, 2'd0);
      add_item(OP_APPEND, 16'h0000, 1'b0, 2'd0);
      add_item(OP_APPEND, 16'h0002, 1'b0, 2'd0);
      add_item(OP_OPEN,   16'hAAAA, 1'b0, 2'd0);
      add_item(OP_APPEND, 16'hFFFF, 1'b0, 2'd0);
      add_item(OP_FINISH, 16'hFFFF, 1'b0, 2'd0);
      // hold until the previous set has drained, then a lone vertex
      add_item(OP_OPEN,   16'h0003, 1'b1, 2'd0);
      add_item(OP_FINISH, 16'h0000, 1'b0, 2'd0);

      rand_count  = 0;
      graphs_made = 0;
      while (rand_count < 30 || graphs_made < 4) begin
         ph = (rand_count < 15) ? 2'd0 : (rand_count < 30) ? 2'd1 : 2'd2;
         nv = $urandom_range(6);
         if ($urandom_range(7) == 0) add_item(OP_APPEND, 16'($urandom), 1'b0, ph);
         for (int v = 0; v < nv; v++) begin
            add_item(OP_OPEN, 16'($urandom), 1'b0, ph);
            rand_count++;
            deg = $urandom_range(3);
            for (int k = 0; k < deg; k++) begin
               pick = $urandom_range(9);
               if (pick < 8)       nb = 16'($urandom_range(nv - 1));
               else if (pick == 8) nb = 16'(nv + $urandom_range(3));
               else                nb = 16'($urandom);
               add_item(OP_APPEND, nb, 1'b0, ph);
               rand_count++;
            end
            if ($urandom_range(19) == 0) add_item(OP_UNUSED, 16'($urandom), 1'b0, ph);
         end
         add_item(OP_FINISH, 16'($urandom), 1'b0, ph);
         rand_count++;
         graphs_made++;
      end

      // too many vertices: dropped opens and the appends behind them
      for (int v = 0; v < 66; v++) begin
         add_item(OP_OPEN, 16'($urandom), 1'b0, 2'd2);
         if (v % 16 == 0 || v >= 64) add_item(OP_APPEND, 16'($urandom_range(63)), 1'b0, 2'd2);
      end
      add_item(OP_FINISH, 16'($urandom), 1'b0, 2'd2);

      total = pending_ops.size();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      wait (items_taken == total);
      wait (picks_due.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
